FILE: sv/eld_pkg.sv
// ----------------------------------------------------------------------------
// eld_pkg
// Types and constants shared by the escaped length frame decoder.
// ----------------------------------------------------------------------------
package eld_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_ESCAPE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_END      = 3'd5;

    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    localparam logic [7:0] BAD_ESCAPE_VALUE = 8'h00;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_DATA   = 3'd3,
        PH_END    = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_RESTART  = 3'd1,
        ST_DONE     = 3'd2,
        ST_DONE_ERR = 3'd3,
        ST_RESET_OK = 3'd4,
        ST_RESET_NO = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_ESCAPE = 2'd1,
        ERR_UNDER  = 2'd2,
        ERR_OVER   = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] escape_byte;
        logic [7:0] escaped_start_code;
        logic [7:0] escaped_escape_code;
        logic [7:0] escaped_end_code;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [7:0] data_byte;
        t_err       error_code;
        logic       byte_taken;
    } t_result;

endpackage

FILE: sv/escaped_length_frame_decoder.sv
// ----------------------------------------------------------------------------
// escaped_length_frame_decoder
// Byte-stuffed, length-prefixed frame decoder, one byte or reset request
// per transaction.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_operation, i_in_byte
//   out     | output    | o_out_valid / i_out_stall| o_status, o_data_byte,
//           |           |                          | o_error_code, o_byte_taken
//   cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_stall is low; each item is held in the input
// register, and its result is registered in the output buffer before it leaves.
// Reset is synchronous, active low; it restores the marker registers and
// clears the frame state. A stalled output fills a two-entry buffer, then
// the input register holds and o_in_stall rises.
// ----------------------------------------------------------------------------
module escaped_length_frame_decoder
    import eld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic [7:0]           i_in_byte,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_status,
    output logic [7:0]           o_data_byte,
    output logic [1:0]           o_error_code,
    output logic                 o_byte_taken,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;
    logic       in_accept;
    logic       advance;
    logic       buf_space;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign o_cfg_ready = 1'b1;

    eld_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign advance    = r_in_valid && buf_space;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op   <= i_operation;
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    eld_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_step      (advance),
        .i_operation (r_in_op),
        .i_in_byte   (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    eld_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_space (buf_space),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_status     = out_res.status;
    assign o_data_byte  = out_res.data_byte;
    assign o_error_code = out_res.error_code;
    assign o_byte_taken = out_res.byte_taken;

endmodule

FILE: sv/eld_cfg_regs.sv
// ----------------------------------------------------------------------------
// eld_cfg_regs
// Marker and escape code registers, written through the config channel.
// ----------------------------------------------------------------------------
module eld_cfg_regs
    import eld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [7:0]           i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                CFG_START_BYTE:  n_cfg.start_byte          = i_data;
                CFG_END_BYTE:    n_cfg.end_byte            = i_data;
                CFG_ESCAPE_BYTE: n_cfg.escape_byte         = i_data;
                CFG_ESC_START:   n_cfg.escaped_start_code  = i_data;
                CFG_ESC_ESCAPE:  n_cfg.escaped_escape_code = i_data;
                CFG_ESC_END:     n_cfg.escaped_end_code    = i_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte          <= 8'd240;
            r_cfg.end_byte            <= 8'd241;
            r_cfg.escape_byte         <= 8'd242;
            r_cfg.escaped_start_code  <= 8'd0;
            r_cfg.escaped_escape_code <= 8'd1;
            r_cfg.escaped_end_code    <= 8'd2;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/eld_core.sv
// ----------------------------------------------------------------------------
// eld_core
// Frame state registers and the per-byte decode logic.
// ----------------------------------------------------------------------------
module eld_core
    import eld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    input  logic       i_operation,
    input  logic [7:0] i_in_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_frame_len, n_frame_len;
    logic [15:0] r_rcvd, n_rcvd;
    logic [15:0] rcvd_inc;
    logic        r_esc, n_esc;
    t_err        r_err, n_err;

    logic       is_start;
    logic       is_end;
    logic [7:0] u_val;
    logic       u_ok;
    logic       u_esc;
    logic       u_bad;
    logic       res_valid;
    t_result    res;

    assign is_start = (i_in_byte == i_cfg.start_byte);
    assign is_end   = (i_in_byte == i_cfg.end_byte);
    assign rcvd_inc = r_rcvd + 16'd1;

    always_comb begin
        u_val = i_in_byte;
        u_ok  = 1'b1;
        u_esc = 1'b0;
        u_bad = 1'b0;
        if (r_esc) begin
            if (i_in_byte == i_cfg.escaped_start_code) begin
                u_val = i_cfg.start_byte;
            end else if (i_in_byte == i_cfg.escaped_escape_code) begin
                u_val = i_cfg.escape_byte;
            end else if (i_in_byte == i_cfg.escaped_end_code) begin
                u_val = i_cfg.end_byte;
            end else begin
                u_val = BAD_ESCAPE_VALUE;
                u_bad = 1'b1;
            end
        end else if (i_in_byte == i_cfg.escape_byte) begin
            u_ok  = 1'b0;
            u_esc = 1'b1;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_frame_len    = r_frame_len;
        n_rcvd         = r_rcvd;
        n_esc          = r_esc;
        n_err          = r_err;
        res_valid      = 1'b0;
        res.status     = ST_DATA;
        res.data_byte  = 8'd0;
        res.error_code = r_err;
        res.byte_taken = 1'b0;

        if (i_operation == OP_RESET) begin
            res_valid = 1'b1;
            if (r_phase == PH_WAIT || r_phase == PH_DONE) begin
                n_phase        = PH_WAIT;
                n_frame_len    = 16'd0;
                n_rcvd         = 16'd0;
                n_esc          = 1'b0;
                n_err          = ERR_NONE;
                res.status     = ST_RESET_OK;
                res.error_code = ERR_NONE;
            end else begin
                res.status = ST_RESET_NO;
            end
        end else if (r_phase == PH_DONE) begin
            res_valid  = 1'b1;
            res.status = (r_err == ERR_NONE) ? ST_DONE : ST_DONE_ERR;
        end else if (is_start && r_rcvd != 16'd0) begin
            n_phase     = PH_WAIT;
            n_frame_len = 16'd0;
            n_rcvd      = 16'd0;
            res_valid   = 1'b1;
            res.status  = ST_RESTART;
        end else begin
            if (is_start) begin
                n_phase     = PH_WAIT;
                n_frame_len = 16'd0;
                n_rcvd      = 16'd0;
            end
            if (is_end) begin
                n_phase = PH_END;
            end
            case (n_phase)
                PH_WAIT: begin
                    if (is_start) begin
                        n_phase = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    n_esc = u_esc;
                    if (u_bad && r_err == ERR_NONE) begin
                        n_err = ERR_ESCAPE;
                    end
                    if (u_ok) begin
                        n_frame_len = {8'd0, u_val};
                        n_phase     = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_esc = u_esc;
                    if (u_bad && r_err == ERR_NONE) begin
                        n_err = ERR_ESCAPE;
                    end
                    if (u_ok) begin
                        n_frame_len = {u_val, r_frame_len[7:0]};
                        n_phase     = (n_frame_len == 16'd0) ? PH_END : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_esc = u_esc;
                    if (u_bad && r_err == ERR_NONE) begin
                        n_err = ERR_ESCAPE;
                    end
                    if (u_ok) begin
                        n_rcvd = rcvd_inc;
                        if (rcvd_inc >= r_frame_len) begin
                            n_phase = PH_END;
                        end
                        res_valid      = 1'b1;
                        res.status     = ST_DATA;
                        res.data_byte  = u_val;
                        res.error_code = n_err;
                        res.byte_taken = 1'b1;
                    end
                end
                PH_END: begin
                    if (is_end) begin
                        n_phase = PH_DONE;
                        if (n_rcvd < n_frame_len && r_err == ERR_NONE) begin
                            n_err = ERR_UNDER;
                        end
                        res_valid      = 1'b1;
                        res.status     = (n_err == ERR_NONE) ? ST_DONE : ST_DONE_ERR;
                        res.error_code = n_err;
                        res.byte_taken = 1'b1;
                    end else if (r_err == ERR_NONE) begin
                        n_err = ERR_OVER;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_frame_len <= 16'd0;
            r_rcvd      <= 16'd0;
            r_esc       <= 1'b0;
            r_err       <= ERR_NONE;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_frame_len <= n_frame_len;
            r_rcvd      <= n_rcvd;
            r_esc       <= n_esc;
            r_err       <= n_err;
        end
    end

    assign o_res_valid = i_step && res_valid;
    assign o_res       = res;

endmodule

FILE: sv/eld_out_buf.sv
// ----------------------------------------------------------------------------
// eld_out_buf
// Two-entry result buffer between the decode logic and the output channel.
// ----------------------------------------------------------------------------
module eld_out_buf
    import eld_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: sv/eld_checker.sv
// ----------------------------------------------------------------------------
// eld_checker
// Port-level checks on the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module eld_checker
    import eld_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 i_operation,
    input logic [7:0]           i_in_byte,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [2:0]           o_status,
    input logic [7:0]           o_data_byte,
    input logic [1:0]           o_error_code,
    input logic                 o_byte_taken,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [7:0]           i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_data_byte) && $stable(o_error_code))
        else $error("output transaction changed while stalled");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DATA |-> o_data_byte == 8'd0)
        else $error("data byte nonzero outside data status");

    a_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_RESTART || o_status == ST_RESET_OK
            || o_status == ST_RESET_NO) |-> !o_byte_taken)
        else $error("byte taken on restart or reset request");

    a_done_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_DONE || o_status == ST_RESET_OK)
            |-> o_error_code == ERR_NONE)
        else $error("clean done or reset ok with error recorded");

    a_done_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_DONE_ERR |-> o_error_code != ERR_NONE)
        else $error("done with error but no error recorded");

endmodule

bind escaped_length_frame_decoder eld_checker u_eld_checker (.*);

FILE: tb/escaped_length_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_length_frame_decoder_tb
// Self-checking bench for the escaped length frame decoder. A queue of framed
// byte transactions (good frames, short, long, bad escapes, restarts, noise,
// reset requests) feeds a clocked driver with random gaps. A clocked monitor
// with random output stalls checks each result field by field against an
// in-bench decoder model. The marker registers are rewritten between bursts.
// ----------------------------------------------------------------------------
module escaped_length_frame_decoder_tb;
    import eld_pkg::*;

    localparam int LIMIT_CYCLES      = 400000;
    localparam int DRAIN_CYCLES      = 12;
    localparam int ITEMS_PER_SETTING = 150;
    localparam int NUM_SETTINGS      = 8;
    localparam int MAX_REPORTS       = 40;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_rx_item;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_operation = OP_DECODE;
    logic [7:0]           i_in_byte   = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [2:0]           o_status;
    logic [7:0]           o_data_byte;
    logic [1:0]           o_error_code;
    logic                 o_byte_taken;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_START_BYTE;
    logic [7:0]           i_cfg_data  = 8'h00;

    escaped_length_frame_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_data_byte  (o_data_byte),
        .o_error_code (o_error_code),
        .o_byte_taken (o_byte_taken),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // decoder model state
    t_cfg        marker_cfg;
    t_phase      frame_phase;
    logic [15:0] frame_len;
    logic [15:0] rx_count;
    logic        esc_pending;
    t_err        first_err;

    t_rx_item    byte_stream[$];
    t_result     frame_results[$];
    int          stream_len  = 0;
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          in_gap      = 0;
    int          out_hold    = 0;
    bit          calm        = 1'b0;
    logic        in_fire     = 1'b0;
    logic        out_fire    = 1'b0;
    t_rx_item    next_item;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < MAX_REPORTS)
            $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        fail_count++;
    endtask

    task automatic clear_frame();
        frame_phase = PH_WAIT;
        frame_len   = 16'h0000;
        rx_count    = 16'h0000;
        esc_pending = 1'b0;
        first_err   = ERR_NONE;
    endtask

    task automatic note_error(input t_err code);
        if (first_err == ERR_NONE)
            first_err = code;
    endtask

    function automatic t_status done_status();
        if (first_err == ERR_NONE)
            return ST_DONE;
        else
            return ST_DONE_ERR;
    endfunction

    task automatic unstuff(input logic [7:0] b, output logic have, output logic [7:0] val);
        have = 1'b1;
        val  = b;
        if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == marker_cfg.escaped_start_code) begin
                val = marker_cfg.start_byte;
            end else if (b == marker_cfg.escaped_escape_code) begin
                val = marker_cfg.escape_byte;
            end else if (b == marker_cfg.escaped_end_code) begin
                val = marker_cfg.end_byte;
            end else begin
                note_error(ERR_ESCAPE);
                val = BAD_ESCAPE_VALUE;
            end
        end else if (b == marker_cfg.escape_byte) begin
            esc_pending = 1'b1;
            have        = 1'b0;
        end
    endtask

    task automatic decode_item(input logic op, input logic [7:0] b);
        t_result     r;
        logic        emit;
        logic        have;
        logic [7:0]  val;
        logic [15:0] had;
        r    = '0;
        emit = 1'b0;
        have = 1'b0;
        val  = 8'h00;
        if (op == OP_RESET) begin
            emit = 1'b1;
            if (frame_phase == PH_WAIT || frame_phase == PH_DONE) begin
                clear_frame();
                r.status = ST_RESET_OK;
            end else begin
                r.status = ST_RESET_NO;
            end
        end else if (frame_phase == PH_DONE) begin
            emit     = 1'b1;
            r.status = done_status();
        end else begin
            if (b == marker_cfg.start_byte) begin
                had         = rx_count;
                frame_phase = PH_WAIT;
                rx_count    = 16'h0000;
                frame_len   = 16'h0000;
                if (had != 16'h0000) begin
                    emit     = 1'b1;
                    r.status = ST_RESTART;
                end
            end
            if (!emit) begin
                if (b == marker_cfg.end_byte)
                    frame_phase = PH_END;
                case (frame_phase)
                    PH_WAIT: begin
                        if (b == marker_cfg.start_byte)
                            frame_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        unstuff(b, have, val);
                        if (have) begin
                            frame_len   = {8'h00, val};
                            frame_phase = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI: begin
                        unstuff(b, have, val);
                        if (have) begin
                            frame_len[15:8] = val;
                            if (frame_len == 16'h0000)
                                frame_phase = PH_END;
                            else
                                frame_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        unstuff(b, have, val);
                        if (have) begin
                            rx_count = rx_count + 16'h0001;
                            if (rx_count >= frame_len)
                                frame_phase = PH_END;
                            emit         = 1'b1;
                            r.status     = ST_DATA;
                            r.data_byte  = val;
                            r.byte_taken = 1'b1;
                        end
                    end
                    PH_END: begin
                        if (b == marker_cfg.end_byte) begin
                            frame_phase = PH_DONE;
                            if (rx_count < frame_len)
                                note_error(ERR_UNDER);
                            emit         = 1'b1;
                            r.status     = done_status();
                            r.byte_taken = 1'b1;
                        end else begin
                            note_error(ERR_OVER);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (emit) begin
            r.error_code = first_err;
            frame_results.push_back(r);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (frame_results.size() == 0) begin
            report_mismatch("unexpected result, status", int'(o_status), 0);
            return;
        end
        want = frame_results.pop_front();
        if (o_status !== want.status)
            report_mismatch("status", int'(o_status), int'(want.status));
        if (o_data_byte !== want.data_byte)
            report_mismatch("data_byte", int'(o_data_byte), int'(want.data_byte));
        if (o_error_code !== want.error_code)
            report_mismatch("error_code", int'(o_error_code), int'(want.error_code));
        if (o_byte_taken !== want.byte_taken)
            report_mismatch("byte_taken", int'(o_byte_taken), int'(want.byte_taken));
    endtask

    // monitor, model update and watchdog
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && i_in_valid && !o_in_stall;
        out_fire <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result();
        if (i_rst_n && i_in_valid && !o_in_stall)
            decode_item(i_operation, i_in_byte);
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (in_gap != 0) begin
                in_gap = in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (byte_stream.size() != 0) begin
                next_item = byte_stream.pop_front();
                i_operation <= next_item.op;
                i_in_byte   <= next_item.data;
                i_in_valid  <= 1'b1;
                in_gap = calm ? 0 : $urandom_range(0, 3);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall
    always @(negedge i_clk) begin
        if (out_fire)
            out_hold = calm ? 0 : $urandom_range(0, 3);
        if (out_hold != 0) begin
            out_hold = out_hold - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic queue_item(input logic op, input logic [7:0] b);
        t_rx_item it;
        it.op   = op;
        it.data = b;
        byte_stream.push_back(it);
        stream_len++;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        queue_item(OP_DECODE, b);
    endtask

    task automatic queue_reset();
        queue_item(OP_RESET, 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_stuffed(input logic [7:0] v);
        if (v == marker_cfg.start_byte) begin
            queue_byte(marker_cfg.escape_byte);
            queue_byte(marker_cfg.escaped_start_code);
        end else if (v == marker_cfg.escape_byte) begin
            queue_byte(marker_cfg.escape_byte);
            queue_byte(marker_cfg.escaped_escape_code);
        end else if (v == marker_cfg.end_byte) begin
            queue_byte(marker_cfg.escape_byte);
            queue_byte(marker_cfg.escaped_end_code);
        end else begin
            queue_byte(v);
        end
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return marker_cfg.start_byte;
            1:       return marker_cfg.end_byte;
            2:       return marker_cfg.escape_byte;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_bad_code();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == marker_cfg.escaped_start_code || b == marker_cfg.escaped_escape_code ||
               b == marker_cfg.escaped_end_code);
        return b;
    endfunction

    function automatic logic [7:0] pick_trailing();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == marker_cfg.start_byte || b == marker_cfg.end_byte);
        return b;
    endfunction

    // kinds: 0-4 good, 5 short, 6 long, 7 bad escape, 8 restart, 9 noise
    task automatic queue_frame();
        int          kind;
        int          n_data;
        int          bad_at;
        int          i;
        logic [15:0] flen;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(0, 5) == 0)
                    queue_reset();
                else
                    queue_byte(($urandom_range(0, 1) == 0) ? pick_data() : pick_bad_code());
            end
            queue_byte(marker_cfg.end_byte);
            queue_reset();
            return;
        end
        flen = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                : $urandom_range(0, 6));
        if (kind == 7 && flen == 0)
            flen = 1;
        n_data = int'(flen);
        if (kind == 5) begin
            flen = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                    : $urandom_range(1, 10));
            n_data = $urandom_range(0, (flen > 10) ? 10 : flen - 1);
        end
        if (kind == 8) begin
            queue_byte(marker_cfg.start_byte);
            queue_stuffed(8'($urandom_range(2, 9)));
            queue_stuffed(8'h00);
            queue_stuffed(pick_data());
            queue_byte(marker_cfg.start_byte);
        end
        bad_at = $urandom_range(0, (n_data > 0) ? n_data - 1 : 0);
        queue_byte(marker_cfg.start_byte);
        queue_stuffed(flen[7:0]);
        queue_stuffed(flen[15:8]);
        for (i = 0; i < n_data; i++) begin
            if (kind == 7 && i == bad_at) begin
                queue_byte(marker_cfg.escape_byte);
                queue_byte(pick_bad_code());
            end else begin
                queue_stuffed(pick_data());
            end
            if ($urandom_range(0, 15) == 0)
                queue_reset();
        end
        if (kind == 6) begin
            repeat ($urandom_range(1, 3))
                queue_byte(pick_trailing());
        end
        queue_byte(marker_cfg.end_byte);
        queue_reset();
    endtask

    function automatic t_cfg random_cfg();
        logic [7:0] v [6];
        int         i;
        int         j;
        bit         clash;
        t_cfg       c;
        for (i = 0; i < 6; i++) begin
            do begin
                v[i]  = 8'($urandom_range(0, 255));
                clash = 1'b0;
                for (j = 0; j < i; j++)
                    if (v[j] == v[i])
                        clash = 1'b1;
            end while (clash);
        end
        c.start_byte          = v[0];
        c.end_byte            = v[1];
        c.escape_byte         = v[2];
        c.escaped_start_code  = v[3];
        c.escaped_escape_code = v[4];
        c.escaped_end_code    = v[5];
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_START_BYTE:  marker_cfg.start_byte          = val;
            CFG_END_BYTE:    marker_cfg.end_byte            = val;
            CFG_ESCAPE_BYTE: marker_cfg.escape_byte         = val;
            CFG_ESC_START:   marker_cfg.escaped_start_code  = val;
            CFG_ESC_ESCAPE:  marker_cfg.escaped_escape_code = val;
            CFG_ESC_END:     marker_cfg.escaped_end_code    = val;
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (byte_stream.size() != 0 || i_in_valid || frame_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_cfg c;
        int   k;
        int   first;
        marker_cfg = '{8'd240, 8'd241, 8'd242, 8'd0, 8'd1, 8'd2};
        clear_frame();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle reset, end while waiting, refused reset in the end phase, zero length,
        // trailing byte, bad escape, refused reset, restart, escaped end marker
        queue_reset();
        queue_byte(marker_cfg.end_byte);
        queue_byte(8'hFF);
        queue_reset();
        queue_byte(marker_cfg.start_byte);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(marker_cfg.end_byte);
        queue_reset();
        queue_byte(marker_cfg.start_byte);
        queue_byte(8'h02);
        queue_byte(8'h00);
        queue_byte(marker_cfg.escape_byte);
        queue_byte(8'h05);
        queue_reset();
        queue_byte(marker_cfg.start_byte);
        queue_byte(marker_cfg.start_byte);
        queue_byte(8'h01);
        queue_byte(8'h00);
        queue_byte(marker_cfg.escape_byte);
        queue_byte(marker_cfg.escaped_end_code);
        queue_byte(marker_cfg.end_byte);
        queue_reset();
        drain();

        for (k = 0; k < NUM_SETTINGS; k++) begin
            case (k)
                0:       c = '{8'h00, 8'hFF, 8'h7F, 8'hFE, 8'h01, 8'h80};
                1:       c = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFE, 8'h7F};
                2:       c = '{8'h10, 8'h20, 8'h00, 8'hFF, 8'h00, 8'h7E};
                3:       c = '{8'h30, 8'h40, 8'hFF, 8'h00, 8'hFF, 8'hFF};
                4:       c = '{8'hAA, 8'hAA, 8'hAA, 8'h11, 8'h11, 8'h00};
                default: c = random_cfg();
            endcase
            calm = (k == 2 || k == 5);
            write_reg(CFG_START_BYTE, c.start_byte);
            write_reg(CFG_END_BYTE, c.end_byte);
            write_reg(CFG_ESCAPE_BYTE, c.escape_byte);
            write_reg(CFG_ESC_START, c.escaped_start_code);
            write_reg(CFG_ESC_ESCAPE, c.escaped_escape_code);
            write_reg(CFG_ESC_END, c.escaped_end_code);
            first = stream_len;
            while (stream_len - first < ITEMS_PER_SETTING)
                queue_frame();
            drain();
        end

        if (frame_results.size() != 0)
            report_mismatch("results still pending", frame_results.size(), 0);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
sv/eld_pkg.sv
sv/eld_cfg_regs.sv
sv/eld_core.sv
sv/eld_out_buf.sv
sv/escaped_length_frame_decoder.sv
sv/eld_checker.sv
tb/escaped_length_frame_decoder_tb.sv
